>>> design/bitmap_page_allocator_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define BPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define BPA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/bpa_pkg.sv
// Types and constants of the bitmap page allocator.
package bpa_pkg;

    localparam int ADDR_W    = 32;
    localparam int CNT_W     = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic [1:0]           t_mode;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // request codes
    localparam t_mode MODE_ALLOC = 2'd0;
    localparam t_mode MODE_FREE  = 2'd1;
    localparam t_mode MODE_INIT  = 2'd2;

    // configuration register indexes
    localparam t_cfg_idx CFG_BASE     = 2'd0;
    localparam t_cfg_idx CFG_COUNT    = 2'd1;
    localparam t_cfg_idx CFG_RESERVED = 2'd2;

    // register reset values
    localparam logic [ADDR_W-1:0] RST_BASE     = 32'd0;
    localparam logic [CNT_W-1:0]  RST_COUNT    = 16'd32768;
    localparam logic [CNT_W-1:0]  RST_RESERVED = 16'd1;

endpackage

>>> design/bpa_ram.sv
// Generic single-port-write, registered-read RAM.
module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/bitmap_page_allocator.sv
// Bitmap first-fit page allocator: top level with map, summary and control.
//
//  channel    | direction | handshake                 | payload
//  -----------+-----------+---------------------------+-------------------------------
//  request    | in        | start, busy               | i_mode, i_page_addr
//  result     | out       | o_valid (one-cycle pulse) | o_alloc_addr, o_success
//  config     | in        | i_cfg_valid, o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Alloc goes through a summary read, a map read, then the map write-back before
// it returns to idle. Free runs the range check with the map read, then the
// write-back; an address outside the pool is answered after the range check.
// Refused requests (not ready, map full, unused mode) are answered from idle;
// init writes one map word a cycle. Synchronous active-low reset leaves the map memory as is:
// nothing reads it before init rewrites it all. The receiver cannot stall results.
`include "bitmap_page_allocator_macros.svh"

module bitmap_page_allocator
    import bpa_pkg::*;
#(
    parameter int MAX_PAGES     = 32768,
    parameter int PAGE_SHIFT    = 12,
    parameter int MAP_WORD_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration writes
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  t_cfg_idx          i_cfg_index,
    input  logic [ADDR_W-1:0] i_cfg_data,
    // requests
    input  logic              start,
    output logic              busy,
    input  t_mode             i_mode,
    input  logic [ADDR_W-1:0] i_page_addr,
    // results
    output logic              o_valid,
    output logic [ADDR_W-1:0] o_alloc_addr,
    output logic              o_success
);

    // Map words are rounded up to a power of two so that page/word splits
    // are plain bit slices.
    localparam int LW        = $clog2(MAP_WORD_BITS);
    localparam int MW        = 1 << LW;
    localparam int MAP_WORDS = (MAX_PAGES + MW - 1) / MW;
    localparam int SUM_WORDS = (MAP_WORDS + MW - 1) / MW;
    localparam int MA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int SA_W      = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
    localparam int XW        = SA_W + LW;          // map word index, summary-aligned
    localparam int PI_W      = XW + LW;            // page index
    localparam int CT_W      = $clog2(MAX_PAGES + 1);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_ALLOC_SUM = 3'd1;
    localparam logic [2:0] S_ALLOC_MAP = 3'd2;
    localparam logic [2:0] S_FREE_CHK  = 3'd3;
    localparam logic [2:0] S_FREE_WR   = 3'd4;
    localparam logic [2:0] S_INIT      = 3'd5;

    // configuration
    logic [ADDR_W-1:0]    r_base;
    logic [CNT_W-1:0]     r_page_count;
    logic [CNT_W-1:0]     r_reserved;

    // control
    logic [2:0]           r_state,      n_state;
    logic                 r_ready,      n_ready;
    logic [SUM_WORDS-1:0] r_top,        n_top;   // 1: summary word all full
    logic                 r_valid,      n_valid;
    logic [ADDR_W-1:0]    r_alloc_addr, n_alloc_addr;
    logic                 r_success,    n_success;

    // working registers
    logic [SA_W-1:0]      r_s,     n_s;
    logic [LW-1:0]        r_j,     n_j;
    logic [XW-1:0]        r_m,     n_m;
    logic [MW-1:0]        r_sword, n_sword;
    logic [ADDR_W-1:0]    r_addr,  n_addr;
    logic [PI_W-1:0]      r_page,  n_page;
    logic [SA_W-1:0]      r_sw,    n_sw;
    logic [LW-1:0]        r_bit,   n_bit;
    logic [MW-1:0]        r_sacc,  n_sacc;

    // memory ports
    logic                 map_we, map_re, sum_we, sum_re;
    logic [MA_W-1:0]      map_waddr, map_raddr;
    logic [SA_W-1:0]      sum_waddr, sum_raddr;
    logic [MW-1:0]        map_wdata, map_rdata, sum_wdata, sum_rdata;

    // derived values
    logic [CT_W-1:0]      eff_cnt;
    logic [ADDR_W-1:0]    page_base;
    logic [SA_W-1:0]      top_s;
    logic                 top_full;
    logic [LW-1:0]        sum_j, map_b;

    logic [PI_W-1:0]      a_page;
    logic                 a_fit;
    logic [MW-1:0]        a_word, a_sword;

    logic [ADDR_W-1:0]    f_diff, f_pg32;
    logic                 f_ok;
    logic [PI_W-1:0]      f_page;
    logic [XW-1:0]        f_w, fr_w;

    logic [XW-1:0]        i_m;
    logic                 i_last, i_bnd;
    logic [MW-1:0]        i_free, i_sacc;

    // ------------------------------------------------------------------
    // Storage: one bit per page, and one "word full" bit per map word.
    // ------------------------------------------------------------------
    bpa_ram #(.WIDTH(MW), .DEPTH(MAP_WORDS)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    bpa_ram #(.WIDTH(MW), .DEPTH(SUM_WORDS)) u_sum (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_re    (sum_re),
        .i_raddr (sum_raddr),
        .o_rdata (sum_rdata)
    );

    // ------------------------------------------------------------------
    // Common terms
    // ------------------------------------------------------------------
    assign eff_cnt   = (32'(r_page_count) < 32'(MAX_PAGES)) ? CT_W'(r_page_count)
                                                            : CT_W'(MAX_PAGES);
    assign page_base = {r_base[ADDR_W-1:PAGE_SHIFT], PAGE_SHIFT'(0)};
    assign top_full  = &r_top;

    // lowest clear bit finders
    always_comb begin
        top_s = '0;
        for (int k = SUM_WORDS - 1; k >= 0; k--) begin
            if (!r_top[k]) top_s = SA_W'(k);
        end
    end

    always_comb begin
        sum_j = '0;
        for (int k = MW - 1; k >= 0; k--) begin
            if (!sum_rdata[k]) sum_j = LW'(k);
        end
    end

    always_comb begin
        map_b = '0;
        for (int k = MW - 1; k >= 0; k--) begin
            if (!map_rdata[k]) map_b = LW'(k);
        end
    end

    // alloc: lowest free page overall; beyond the count means none usable
    assign a_page  = {r_m, map_b};
    assign a_fit   = 32'(a_page) < 32'(eff_cnt);
    assign a_word  = map_rdata | (MW'(1) << map_b);
    assign a_sword = r_sword | (MW'(1) << r_j);

    // free: range check on the latched address
    assign f_diff = r_addr - page_base;
    assign f_pg32 = f_diff >> PAGE_SHIFT;
    assign f_ok   = (r_addr >= page_base) && (f_pg32 < 32'(eff_cnt));
    assign f_page = f_pg32[PI_W-1:0];
    assign f_w    = f_page[PI_W-1:LW];
    assign fr_w   = r_page[PI_W-1:LW];

    // init sweep: word data is free where reserved <= page < count
    assign i_m    = {r_sw, r_bit};
    assign i_last = (i_m == XW'(MAP_WORDS - 1));
    assign i_bnd  = (r_bit == LW'(MW - 1)) || i_last;

    always_comb begin
        for (int k = 0; k < MW; k++) begin
            i_free[k] = (32'({i_m, LW'(k)}) >= 32'(r_reserved))
                     && (32'({i_m, LW'(k)}) <  32'(eff_cnt));
        end
        i_sacc        = r_sacc;
        i_sacc[r_bit] = ~|i_free;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_ready      = r_ready;
        n_top        = r_top;
        n_valid      = 1'b0;
        n_alloc_addr = r_alloc_addr;
        n_success    = r_success;
        n_s          = r_s;
        n_j          = r_j;
        n_m          = r_m;
        n_sword      = r_sword;
        n_addr       = r_addr;
        n_page       = r_page;
        n_sw         = r_sw;
        n_bit        = r_bit;
        n_sacc       = r_sacc;

        map_we    = 1'b0;
        map_waddr = '0;
        map_wdata = '0;
        map_re    = 1'b0;
        map_raddr = '0;
        sum_we    = 1'b0;
        sum_waddr = '0;
        sum_wdata = '0;
        sum_re    = 1'b0;
        sum_raddr = '0;

        case (r_state)
            S_IDLE: begin
                // summary word of the first non-full group is prefetched
                sum_re    = 1'b1;
                sum_raddr = top_s;
                if (start) begin
                    n_alloc_addr = '0;
                    n_success    = 1'b0;
                    case (i_mode)
                        MODE_ALLOC: begin
                            if (r_ready && !top_full) begin
                                n_s     = top_s;
                                n_state = S_ALLOC_SUM;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        MODE_FREE: begin
                            if (r_ready) begin
                                n_addr  = i_page_addr;
                                n_state = S_FREE_CHK;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        MODE_INIT: begin
                            n_sw    = '0;
                            n_bit   = '0;
                            n_sacc  = '1;
                            n_state = S_INIT;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end

            S_ALLOC_SUM: begin
                n_j       = sum_j;
                n_sword   = sum_rdata;
                n_m       = {r_s, sum_j};
                map_re    = 1'b1;
                map_raddr = MA_W'({r_s, sum_j});
                n_state   = S_ALLOC_MAP;
            end

            S_ALLOC_MAP: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
                if (a_fit) begin
                    map_we       = 1'b1;
                    map_waddr    = MA_W'(r_m);
                    map_wdata    = a_word;
                    n_success    = 1'b1;
                    n_alloc_addr = page_base + (32'(a_page) << PAGE_SHIFT);
                    if (&a_word) begin
                        sum_we     = 1'b1;
                        sum_waddr  = r_s;
                        sum_wdata  = a_sword;
                        n_top[r_s] = &a_sword;
                    end
                end
            end

            S_FREE_CHK: begin
                if (f_ok) begin
                    n_page    = f_page;
                    map_re    = 1'b1;
                    map_raddr = MA_W'(f_w);
                    sum_re    = 1'b1;
                    sum_raddr = f_w[XW-1:LW];
                    n_state   = S_FREE_WR;
                end else begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_FREE_WR: begin
                // double free just clears again
                map_we    = 1'b1;
                map_waddr = MA_W'(fr_w);
                map_wdata = map_rdata & ~(MW'(1) << r_page[LW-1:0]);
                sum_we    = 1'b1;
                sum_waddr = fr_w[XW-1:LW];
                sum_wdata = sum_rdata & ~(MW'(1) << fr_w[LW-1:0]);
                n_top[fr_w[XW-1:LW]] = 1'b0;
                n_success = 1'b1;
                n_valid   = 1'b1;
                n_state   = S_IDLE;
            end

            S_INIT: begin
                map_we    = 1'b1;
                map_waddr = MA_W'(i_m);
                map_wdata = ~i_free;
                n_sacc    = i_sacc;
                n_bit     = r_bit + 1'b1;
                if (i_bnd) begin
                    // summary word complete; missing tail entries stay full
                    sum_we      = 1'b1;
                    sum_waddr   = r_sw;
                    sum_wdata   = i_sacc;
                    n_top[r_sw] = &i_sacc;
                    n_sacc      = '1;
                    n_sw        = r_sw + 1'b1;
                    n_bit       = '0;
                end
                if (i_last) begin
                    n_ready   = 1'b1;
                    n_success = 1'b1;
                    n_valid   = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ready      <= 1'b0;
            r_top        <= '1;
            r_valid      <= 1'b0;
            r_base       <= RST_BASE;
            r_page_count <= RST_COUNT;
            r_reserved   <= RST_RESERVED;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
            r_top   <= n_top;
            r_valid <= n_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_BASE:     r_base       <= i_cfg_data;
                    CFG_COUNT:    r_page_count <= i_cfg_data[CNT_W-1:0];
                    CFG_RESERVED: r_reserved   <= i_cfg_data[CNT_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_alloc_addr <= n_alloc_addr;
        r_success    <= n_success;
        r_s          <= n_s;
        r_j          <= n_j;
        r_m          <= n_m;
        r_sword      <= n_sword;
        r_addr       <= n_addr;
        r_page       <= n_page;
        r_sw         <= n_sw;
        r_bit        <= n_bit;
        r_sacc       <= n_sacc;
    end

    assign o_cfg_ready  = 1'b1;
    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_alloc_addr = r_alloc_addr;
    assign o_success    = r_success;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `BPA_ASSERT_IMP(a_result_src, r_valid,
        $past(start && !busy) || $past(r_state != S_IDLE),
        "result strobe without an accepted request")
    `BPA_ASSERT_IMP(a_sum_chosen, r_state == S_ALLOC_SUM, !r_top[r_s],
        "alloc picked a summary group marked full")
    `BPA_ASSERT_IMP(a_map_hit, r_state == S_ALLOC_MAP, !(&map_rdata),
        "summary pointed at a full map word")
    `BPA_ASSERT_IMP(a_sum_with_map, sum_we, map_we,
        "summary written without a map write")
    `BPA_ASSERT_NXT(a_init_done, (r_state == S_INIT) && i_last,
        r_ready && r_valid && r_success && !busy,
        "init sweep did not finish cleanly")

endmodule

>>> sim/bitmap_page_allocator_tb.sv
// Self-checking testbench for the bitmap first-fit page allocator.
module bitmap_page_allocator_tb
    import bpa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Geometry of the default build of the block.
    localparam int MAX_PAGES     = 32768;
    localparam int PAGE_SHIFT    = 12;
    localparam int MAP_WORD_BITS = 32;
    localparam int MAP_WORDS     = MAX_PAGES / MAP_WORD_BITS;

    // Codes the package leaves unnamed.
    localparam t_mode    MODE_UNUSED = 2'd3;
    localparam t_cfg_idx CFG_SPARE   = 2'd3;

    // Longest run of cycles with no handshake at all. It has to cover an init
    // sweep, plus a sender gap and a register write pause.
    localparam int STALL_LIMIT = 8 * MAP_WORDS;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              ok;
    } t_reply;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    t_cfg_idx          i_cfg_index;
    logic [ADDR_W-1:0] i_cfg_data;
    logic              start;
    logic              busy;
    t_mode             i_mode;
    logic [ADDR_W-1:0] i_page_addr;
    logic              o_valid;
    logic [ADDR_W-1:0] o_alloc_addr;
    logic              o_success;

    bitmap_page_allocator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_page_addr  (i_page_addr),
        .o_valid      (o_valid),
        .o_alloc_addr (o_alloc_addr),
        .o_success    (o_success)
    );

    // ------------------------------------------------------------------
    // Shadow of the allocator: used map, ready flag and the registers.
    // ------------------------------------------------------------------
    bit [MAP_WORD_BITS-1:0] shadow_map [MAP_WORDS];
    bit                     shadow_ready;
    logic [ADDR_W-1:0]      shadow_base;
    logic [CNT_W-1:0]       shadow_count;
    logic [CNT_W-1:0]       shadow_reserved;

    t_reply            reply_q [$];   // replies owed by the block, oldest first
    logic [ADDR_W-1:0] held_q [$];    // addresses handed out and not yet freed
    logic [ADDR_W-1:0] freed_q [$];   // recently freed, for double frees

    int gap_pct;                      // chance in 100 of a sender idle cycle
    int mismatches;
    int replies_checked;
    int n_alloc_ok, n_alloc_refused, n_free_ok, n_free_ignored, n_init;
    int n_reg_writes;
    int quiet_cycles;

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Any handshake on any channel counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("bitmap_page_allocator_tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Shadow update for one accepted request; returns the reply it owes.
    // ------------------------------------------------------------------
    function automatic int unsigned live_pages();
        return (shadow_count < MAX_PAGES) ? shadow_count : MAX_PAGES;
    endfunction

    function automatic t_reply page_op_outcome(t_mode mode, logic [ADDR_W-1:0] addr);
        t_reply            r;
        int unsigned       lim;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] pg;
        bit                found;
        r     = '0;
        found = 1'b0;
        lim   = live_pages();
        base  = shadow_base & ~((32'd1 << PAGE_SHIFT) - 32'd1);
        case (mode)
            MODE_INIT: begin
                foreach (shadow_map[w]) shadow_map[w] = '1;
                for (int p = shadow_reserved; p < lim; p++)
                    shadow_map[p / MAP_WORD_BITS][p % MAP_WORD_BITS] = 1'b0;
                shadow_ready = 1'b1;
                r.ok = 1'b1;
            end
            MODE_ALLOC: begin
                // first fit: lowest clear bit below the live page count
                if (shadow_ready) begin
                    for (int w = 0; w < MAP_WORDS && !found; w++) begin
                        if (shadow_map[w] != '1) begin
                            for (int b = 0; b < MAP_WORD_BITS && !found; b++) begin
                                if (w * MAP_WORD_BITS + b >= lim) break;
                                if (!shadow_map[w][b]) begin
                                    shadow_map[w][b] = 1'b1;
                                    pg     = w * MAP_WORD_BITS + b;
                                    r.addr = base + (pg << PAGE_SHIFT);
                                    r.ok   = 1'b1;
                                    found  = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            MODE_FREE: begin
                if (shadow_ready && addr >= base) begin
                    pg = (addr - base) >> PAGE_SHIFT;
                    if (pg < lim) begin
                        shadow_map[pg / MAP_WORD_BITS][pg % MAP_WORD_BITS] = 1'b0;
                        r.ok = 1'b1;
                    end
                end
            end
            default: ;   // unused mode: no effect
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every strobe pops the oldest owed reply.
    // ------------------------------------------------------------------
    t_reply owed;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (reply_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing owed: addr=%h success=%b",
                             $realtime, o_alloc_addr, o_success);
            end else begin
                owed = reply_q.pop_front();
                replies_checked++;
                if (o_alloc_addr !== owed.addr || o_success !== owed.ok) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: reply %0d: want addr=%h success=%b, got addr=%h success=%b",
                                 $realtime, replies_checked, owed.addr, owed.ok,
                                 o_alloc_addr, o_success);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driving tasks. Inputs move on the falling edge, handshakes are
    // sampled on the rising edge.
    // ------------------------------------------------------------------

    // One request; start stays high afterwards so back-to-back requests
    // keep the line asserted. Each cycle the sender idles with gap_pct odds.
    task automatic send_req(t_mode mode, logic [ADDR_W-1:0] addr);
        int     gap;
        t_reply r;
        gap = 0;
        while ($urandom_range(0, 99) < gap_pct) gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            start       = 1'b0;
            i_mode      = t_mode'($urandom_range(0, 3));   // junk while idle
            i_page_addr = $urandom;
            repeat (gap) @(negedge i_clk);
        end
        start       = 1'b1;
        i_mode      = mode;
        i_page_addr = addr;
        do @(posedge i_clk); while (busy);
        r = page_op_outcome(mode, addr);
        reply_q.push_back(r);
        case (mode)
            MODE_ALLOC: begin
                if (r.ok) begin
                    n_alloc_ok++;
                    held_q.push_back(r.addr);
                end else begin
                    n_alloc_refused++;
                end
            end
            MODE_FREE: begin
                if (r.ok) n_free_ok++;
                else n_free_ignored++;
            end
            MODE_INIT: begin
                n_init++;
                held_q.delete();
                freed_q.delete();
            end
            default: ;
        endcase
    endtask

    // Drop start and let every owed reply come back.
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // Register write, only with the block idle.
    task automatic write_reg(t_cfg_idx idx, logic [ADDR_W-1:0] data);
        drain();
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_BASE:     shadow_base     = data;
            CFG_COUNT:    shadow_count    = data[CNT_W-1:0];
            CFG_RESERVED: shadow_reserved = data[CNT_W-1:0];
            default: ;
        endcase
        n_reg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        i_cfg_data  = $urandom;
    endtask

    // Count and reserved registers are 16 bits; junk in the upper half.
    task automatic set_pool(logic [ADDR_W-1:0] base, logic [CNT_W-1:0] count,
                            logic [CNT_W-1:0] reserved);
        write_reg(CFG_BASE, base);
        write_reg(CFG_COUNT, {16'($urandom), count});
        write_reg(CFG_RESERVED, {16'($urandom), reserved});
        held_q.delete();
        freed_q.delete();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Before any init: alloc and free are refused, unused mode too.
    task automatic test_not_ready();
        send_req(MODE_ALLOC, $urandom);
        send_req(MODE_FREE, 32'h0000_1000);
        send_req(MODE_UNUSED, $urandom);
    endtask

    // Four-page pool with one reserved page and an unaligned base.
    task automatic test_small_pool();
        set_pool(32'h0004_5ABC, 16'd4, 16'd1);
        send_req(MODE_INIT, $urandom);
        repeat (4) send_req(MODE_ALLOC, $urandom);     // pages 1..3, then full
        send_req(MODE_FREE, 32'h0004_7FFF);            // page 2, offset in page
        send_req(MODE_FREE, 32'h0004_7000);            // same page again
        send_req(MODE_ALLOC, $urandom);                // hole at page 2 reused
        send_req(MODE_FREE, 32'h0004_9000);            // first page past count
        send_req(MODE_FREE, 32'h0004_5000);            // reserved page is freeable
        send_req(MODE_ALLOC, $urandom);                // ... and comes back first
    endtask

    // Register extremes: top base with wrap, count above capacity,
    // reserved beyond count, empty pool, spare register index.
    task automatic test_capacity_edges();
        set_pool(32'hFFFF_FFFF, 16'hFFFF, 16'd32767);
        send_req(MODE_INIT, $urandom);
        send_req(MODE_ALLOC, $urandom);                // last page, address wraps
        send_req(MODE_ALLOC, $urandom);                // full
        send_req(MODE_FREE, 32'hFFFF_FFFF);            // page 0
        send_req(MODE_FREE, 32'h0000_0123);            // below base
        set_pool(32'h0000_0000, 16'd3, 16'hFFFF);
        send_req(MODE_INIT, $urandom);
        send_req(MODE_ALLOC, $urandom);                // nothing free
        set_pool($urandom, 16'd0, 16'd0);
        send_req(MODE_INIT, $urandom);
        send_req(MODE_ALLOC, $urandom);
        send_req(MODE_FREE, shadow_base);              // page 0 not managed
        write_reg(CFG_SPARE, $urandom);                // must change nothing
    endtask

    // Count changed after init without a new init.
    task automatic test_live_reconfig();
        set_pool(32'h0000_0000, 16'd8, 16'd0);
        send_req(MODE_INIT, $urandom);
        write_reg(CFG_COUNT, 32'd2);
        repeat (3) send_req(MODE_ALLOC, $urandom);     // pages 0, 1, then refused
        write_reg(CFG_COUNT, 32'd8);
        send_req(MODE_ALLOC, $urandom);                // page 2
        send_req(MODE_FREE, 32'h0000_1000);
    endtask

    // One random phase: set the pool, init, then mostly well-formed
    // alloc/free traffic with some noise mixed in.
    task automatic random_phase(int kind, int items);
        logic [ADDR_W-1:0] base, addr;
        logic [CNT_W-1:0]  count, reserved;
        int                sel, pick;
        bit                reconf;
        case (kind)
            0: begin   // tiny pool, fills and drains often
                count    = CNT_W'($urandom_range(1, 64));
                reserved = ($urandom_range(0, 9) == 0)
                         ? CNT_W'(count + $urandom_range(0, 2))
                         : CNT_W'($urandom_range(0, count / 4));
                base     = $urandom;
            end
            1: begin   // pool at the top of the address space
                count    = CNT_W'($urandom_range(33, 200));
                reserved = CNT_W'($urandom_range(0, 3));
                base     = 32'hFFF0_0000 | $urandom;
            end
            2: begin   // only the last pages free, count at or past capacity
                count    = CNT_W'($urandom_range(MAX_PAGES, 16'hFFFF));
                reserved = CNT_W'(MAX_PAGES - $urandom_range(5, 40));
                base     = $urandom;
            end
            default: begin   // large pool, low pages only
                count    = CNT_W'(MAX_PAGES);
                reserved = CNT_W'($urandom_range(0, 2));
                base     = $urandom_range(0, 255) << PAGE_SHIFT;
            end
        endcase
        set_pool(base, count, reserved);
        base   = shadow_base & ~((32'd1 << PAGE_SHIFT) - 32'd1);
        reconf = ($urandom_range(0, 2) == 0);
        send_req(MODE_INIT, $urandom);
        for (int i = 0; i < items; i++) begin
            if (reconf && i == items / 2)
                write_reg(CFG_COUNT, $urandom_range(0, live_pages() + 8));
            sel = $urandom_range(0, 99);
            if (sel < 80 && sel >= 48 && held_q.size() == 0) sel = 0;
            if (sel < 48) begin
                send_req(MODE_ALLOC, $urandom);
            end else if (sel < 80) begin
                pick = $urandom_range(0, held_q.size() - 1);
                addr = held_q[pick];
                held_q.delete(pick);
                freed_q.push_back(addr);
                if (freed_q.size() > 8) void'(freed_q.pop_front());
                send_req(MODE_FREE, addr | $urandom_range(0, (1 << PAGE_SHIFT) - 1));
            end else if (sel < 86) begin
                // double free, or any page up to a little past the count
                if (freed_q.size() != 0 && sel < 83)
                    addr = freed_q[$urandom_range(0, freed_q.size() - 1)];
                else
                    addr = base + ($urandom_range(0, live_pages() + 2) << PAGE_SHIFT);
                send_req(MODE_FREE, addr);
            end else if (sel < 91) begin
                send_req(MODE_FREE, $urandom);
            end else if (sel < 94) begin
                send_req(MODE_INIT, $urandom);
            end else if (sel < 97) begin
                send_req(MODE_UNUSED, $urandom);
            end else begin
                send_req(MODE_FREE, base - $urandom_range(1, 2 << PAGE_SHIFT));
            end
        end
    endtask

    // Twelve phases: sender gaps at 34%, then 52%, then none.
    task automatic test_random_traffic();
        for (int ph = 0; ph < 12; ph++) begin
            gap_pct = (ph < 4) ? 34 : (ph < 8) ? 52 : 0;
            random_phase(ph % 4, 127);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_BASE;
        i_cfg_data  = '0;
        start       = 1'b0;
        i_mode      = MODE_ALLOC;
        i_page_addr = '0;
        quiet_cycles = 0;
        mismatches = 0;
        replies_checked = 0;
        n_alloc_ok = 0;
        n_alloc_refused = 0;
        n_free_ok = 0;
        n_free_ignored = 0;
        n_init = 0;
        n_reg_writes = 0;
        gap_pct = 34;

        // shadow starts at the register reset values with every page used
        foreach (shadow_map[w]) shadow_map[w] = '1;
        shadow_ready    = 1'b0;
        shadow_base     = RST_BASE;
        shadow_count    = RST_COUNT;
        shadow_reserved = RST_RESERVED;

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_not_ready();
        test_small_pool();
        test_capacity_edges();
        test_live_reconfig();
        test_random_traffic();

        drain();
        repeat (20) @(posedge i_clk);

        $display("checked %0d replies: %0d allocs granted, %0d refused, %0d frees applied",
                 replies_checked, n_alloc_ok, n_alloc_refused, n_free_ok);
        $display("%0d frees ignored, %0d inits, %0d register writes, %0d mismatches",
                 n_free_ignored, n_init, n_reg_writes, mismatches);
        if (mismatches == 0 && reply_q.size() == 0)
            $display("bitmap_page_allocator_tb OK");
        else
            $display("bitmap_page_allocator_tb NOT OK");
        $finish;
    end

endmodule
